[rtl/anchor_box_decoder_top_assert.svh]
// Assertion macros for the anchor box decoder RTL.
// Used by the modules that check their own control logic; needs clk_i and rst_ni in scope.
`ifndef ANCHOR_BOX_DECODER_TOP_ASSERT_SVH
`define ANCHOR_BOX_DECODER_TOP_ASSERT_SVH

// checked only out of reset
`define ABD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define ABD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/abd_pkg.sv]
// Shared types, constants and helpers of the anchor box decoder.
// No dependencies.
package abd_pkg;

  localparam int unsigned NumAnchors = 896;
  localparam int unsigned Grid16Count = 512;
  localparam int unsigned RatioFrac = 16;
  localparam int unsigned RatioW = 28;
  localparam int unsigned DivSteps = RatioW;

  // (v * 171) >> 10 equals v / 6 for v below 512
  localparam logic [7:0] Div6Mul = 8'd171;
  localparam int unsigned Div6Shift = 10;

  localparam logic [2:0] CfgScoreThr = 3'd0;
  localparam logic [2:0] CfgNumDet   = 3'd1;
  localparam logic [2:0] CfgImgW     = 3'd2;
  localparam logic [2:0] CfgImgH     = 3'd3;
  localparam logic [2:0] CfgModelW   = 3'd4;
  localparam logic [2:0] CfgModelH   = 3'd5;
  localparam logic [2:0] CfgAnchorW  = 3'd6;
  localparam logic [2:0] CfgAnchorH  = 3'd7;

  localparam logic [15:0] ScoreThrRst = 16'd55706;
  localparam logic [9:0]  NumDetRst   = 10'd896;
  localparam logic [11:0] ImgWRst     = 12'd640;
  localparam logic [11:0] ImgHRst     = 12'd480;
  localparam logic [10:0] ModelWRst   = 11'd128;
  localparam logic [10:0] ModelHRst   = 11'd128;
  localparam logic [10:0] AnchorWRst  = 11'd128;
  localparam logic [10:0] AnchorHRst  = 11'd128;

  typedef struct packed {
    logic        [9:0]  det_index;
    logic        [15:0] score;
    logic signed [15:0] off_x;
    logic signed [15:0] off_y;
    logic signed [15:0] box_w;
    logic signed [15:0] box_h;
  } abd_in_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] side_w;
    logic signed [15:0] side_h;
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;
    logic        [15:0] out_score;
    logic        [9:0]  out_index;
  } abd_out_t;

  typedef struct packed {
    logic [15:0]       score_thr;
    logic [9:0]        num_det;
    logic [10:0]       anchor_w;
    logic [10:0]       anchor_h;
    logic [RatioW-1:0] ratio_x;
    logic [RatioW-1:0] ratio_y;
  } abd_cfg_t;

  function automatic logic signed [15:0] sat16(input logic signed [27:0] v);
    logic signed [15:0] r;
    if (v > 28'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -28'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[rtl/anchor_box_decoder_top.sv]
// Top level of the anchor box decoder: config block plus decode pipeline.
// Depends on abd_pkg, abd_cfg, abd_pipe.
//
//   port group   dir  handshake               word
//   in_*         in   in_valid_i/in_stall_o   abd_pkg::abd_in_t
//   out_*        out  out_valid_o/out_stall_i abd_pkg::abd_out_t
//   cfg_*        in   cfg_we_i                index 3b, data 16b
//
// One word per cycle sustained while the output is not stalled and no ratio update runs.
// Dropped words (index out of range, score not above threshold) give no output word.
// After reset, and after any write to an image or model size, both ratios are
// recomputed by the serial dividers, and the input stalls until both are done.
// A stalled output holds its word; earlier stages keep filling until full.
module anchor_box_decoder_top #(
  parameter int unsigned NumAnchors = abd_pkg::NumAnchors
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  abd_pkg::abd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output abd_pkg::abd_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  abd_pkg::abd_cfg_t cfg;
  logic              cfg_busy;

  abd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .busy_o      (cfg_busy)
  );

  abd_pipe #(
    .NumAnchors (NumAnchors)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cfg_busy_i  (cfg_busy),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/abd_div.sv]
// Bit-serial restoring divider: ratio = (num << 16) / den, one quotient bit per cycle.
// Depends on abd_pkg.
module abd_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [11:0]                  num_i,
  input  logic [10:0]                  den_i,
  output logic [abd_pkg::RatioW-1:0]   ratio_o,
  output logic                         busy_o
);

  localparam int unsigned CntW = $clog2(abd_pkg::DivSteps + 1);

  logic [abd_pkg::RatioW-1:0] quo_q, quo_d;
  logic [10:0]                rem_q, rem_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [11:0]                trial;
  logic                       ge;

  assign trial = {rem_q, quo_q[abd_pkg::RatioW-1]};
  assign ge    = trial >= {1'b0, den_i};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (start_i) begin
      quo_d = {num_i, {abd_pkg::RatioFrac{1'b0}}};
      rem_d = '0;
      cnt_d = CntW'(abd_pkg::DivSteps);
    end else if (cnt_q != '0) begin
      quo_d = {quo_q[abd_pkg::RatioW-2:0], ge};
      rem_d = ge ? 11'(trial - {1'b0, den_i}) : trial[10:0];
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign ratio_o = quo_q;
  assign busy_o  = cnt_q != '0;

  `include "anchor_box_decoder_top_assert.svh"

  `ABD_ASSERT(a_div_start_busy, start_i |=> busy_o, "divider idle after start")
  `ABD_ASSERT_ALWAYS(a_div_cnt_range, !rst_ni || (cnt_q <= CntW'(abd_pkg::DivSteps)), "divider count overrun")

endmodule

[rtl/abd_cfg.sv]
// Configuration registers and the two ratio dividers fed from them.
// Depends on abd_pkg and abd_div.
module abd_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output abd_pkg::abd_cfg_t cfg_o,
  output logic              busy_o
);

  logic [15:0] score_thr_q;
  logic [9:0]  num_det_q;
  logic [11:0] img_w_q, img_h_q;
  logic [10:0] model_w_q, model_h_q, anchor_w_q, anchor_h_q;
  logic        start_q, start_d;
  logic [10:0] den_x, den_y;
  logic        busy_x, busy_y;
  logic [abd_pkg::RatioW-1:0] ratio_x, ratio_y;

  always_comb begin
    start_d = 1'b0;
    if (cfg_we_i) begin
      start_d = (cfg_index_i == abd_pkg::CfgImgW) || (cfg_index_i == abd_pkg::CfgImgH) ||
                (cfg_index_i == abd_pkg::CfgModelW) || (cfg_index_i == abd_pkg::CfgModelH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_thr_q <= abd_pkg::ScoreThrRst;
      num_det_q   <= abd_pkg::NumDetRst;
      img_w_q     <= abd_pkg::ImgWRst;
      img_h_q     <= abd_pkg::ImgHRst;
      model_w_q   <= abd_pkg::ModelWRst;
      model_h_q   <= abd_pkg::ModelHRst;
      anchor_w_q  <= abd_pkg::AnchorWRst;
      anchor_h_q  <= abd_pkg::AnchorHRst;
      start_q     <= 1'b1;  // ratios are worked out after reset
    end else begin
      start_q <= start_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          abd_pkg::CfgScoreThr: score_thr_q <= cfg_data_i;
          abd_pkg::CfgNumDet:   num_det_q   <= cfg_data_i[9:0];
          abd_pkg::CfgImgW:     img_w_q     <= cfg_data_i[11:0];
          abd_pkg::CfgImgH:     img_h_q     <= cfg_data_i[11:0];
          abd_pkg::CfgModelW:   model_w_q   <= cfg_data_i[10:0];
          abd_pkg::CfgModelH:   model_h_q   <= cfg_data_i[10:0];
          abd_pkg::CfgAnchorW:  anchor_w_q  <= cfg_data_i[10:0];
          abd_pkg::CfgAnchorH:  anchor_h_q  <= cfg_data_i[10:0];
          default: ;
        endcase
      end
    end
  end

  // zero model size divides as one
  assign den_x = (model_w_q == '0) ? 11'd1 : model_w_q;
  assign den_y = (model_h_q == '0) ? 11'd1 : model_h_q;

  abd_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .num_i   (img_w_q),
    .den_i   (den_x),
    .ratio_o (ratio_x),
    .busy_o  (busy_x)
  );

  abd_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .num_i   (img_h_q),
    .den_i   (den_y),
    .ratio_o (ratio_y),
    .busy_o  (busy_y)
  );

  assign busy_o = start_q | busy_x | busy_y;

  assign cfg_o.score_thr = score_thr_q;
  assign cfg_o.num_det   = num_det_q;
  assign cfg_o.anchor_w  = anchor_w_q;
  assign cfg_o.anchor_h  = anchor_h_q;
  assign cfg_o.ratio_x   = ratio_x;
  assign cfg_o.ratio_y   = ratio_y;

endmodule

[rtl/abd_pipe.sv]
// Six-stage decode pipeline: filter, anchor, centre, scale, truncate, square/saturate.
// Depends on abd_pkg; config comes from abd_cfg.
module abd_pipe #(
  parameter int unsigned NumAnchors = abd_pkg::NumAnchors
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  abd_pkg::abd_cfg_t cfg_i,
  input  logic              cfg_busy_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  abd_pkg::abd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output abd_pkg::abd_out_t out_data_o
);

  logic [6:1] v_q;
  logic [7:1] adv;
  logic       in_acc, keep;

  // stage 1
  logic [8:0]  v8;
  logic [16:0] c8_prod;
  logic [6:0]  cell8;
  logic [4:0]  fx_d, fy_d;
  logic        g16_d;
  logic [9:0]  s1_idx_q;
  logic [15:0] s1_score_q;
  logic signed [15:0] s1_ox_q, s1_oy_q, s1_bw_q, s1_bh_q;
  logic [4:0]  s1_fx_q, s1_fy_q;
  logic        s1_g16_q;

  // stage 2
  logic [15:0] axf, ayf, ax_d, ay_d;
  logic signed [17:0] bw_e, bh_e;
  logic [9:0]  s2_idx_q;
  logic [15:0] s2_score_q, s2_ax_q, s2_ay_q;
  logic signed [15:0] s2_ox_q, s2_oy_q;
  logic signed [17:0] s2_bw3_q, s2_bh3_q;

  // stage 3
  logic signed [17:0] cx_d, cy_d;
  logic signed [20:0] dx_d, dy_d;
  logic [9:0]  s3_idx_q;
  logic [15:0] s3_score_q;
  logic signed [17:0] s3_cx_q, s3_cy_q, s3_bw3_q, s3_bh3_q;
  logic signed [20:0] s3_dx_q, s3_dy_q;

  // stage 4
  logic signed [28:0] rxs, rys;
  logic signed [49:0] px_d, py_d;
  logic signed [46:0] pw_d, ph_d;
  logic [9:0]  s4_idx_q;
  logic [15:0] s4_score_q;
  logic signed [17:0] s4_cx_q, s4_cy_q;
  logic signed [49:0] s4_px_q, s4_py_q;
  logic signed [46:0] s4_pw_q, s4_ph_q;

  // stage 5
  logic signed [49:0] px_b, py_b;
  logic signed [46:0] pw_b, ph_b;
  logic [9:0]  s5_idx_q;
  logic [15:0] s5_score_q;
  logic signed [17:0] s5_cx_q, s5_cy_q;
  logic signed [27:0] s5_left_q, s5_top_q;
  logic signed [25:0] s5_w_q, s5_h_q;

  // stage 6
  logic signed [25:0] side;
  abd_pkg::abd_out_t  s6_q;

  assign adv[7] = !out_stall_i;
  for (genvar k = 1; k <= 6; k++) begin : g_adv
    assign adv[k] = !v_q[k] || adv[k+1];
  end

  assign in_stall_o = !adv[1] || cfg_busy_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign keep = (in_data_i.det_index < cfg_i.num_det) &&
                (in_data_i.det_index < 10'(NumAnchors)) &&
                (in_data_i.score > cfg_i.score_thr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) v_q[1] <= in_acc && keep;
      for (int k = 2; k <= 6; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // anchor multipliers (2g+1) from the index
  assign v8      = in_data_i.det_index[8:0];
  assign c8_prod = 17'(v8) * 17'(abd_pkg::Div6Mul);
  assign cell8   = c8_prod[abd_pkg::Div6Shift +: 7];
  assign g16_d   = in_data_i.det_index < 10'(abd_pkg::Grid16Count);
  assign fx_d    = g16_d ? {in_data_i.det_index[4:1], 1'b1} : {1'b0, cell8[2:0], 1'b1};
  assign fy_d    = g16_d ? {in_data_i.det_index[8:5], 1'b1} : {cell8[6:3], 1'b1};

  assign axf  = 16'(cfg_i.anchor_w) * 16'(s1_fx_q);
  assign ayf  = 16'(cfg_i.anchor_h) * 16'(s1_fy_q);
  assign ax_d = s1_g16_q ? {1'b0, axf[15:1]} : axf;
  assign ay_d = s1_g16_q ? {1'b0, ayf[15:1]} : ayf;
  assign bw_e = {{2{s1_bw_q[15]}}, s1_bw_q};
  assign bh_e = {{2{s1_bh_q[15]}}, s1_bh_q};

  assign cx_d = {{2{s2_ox_q[15]}}, s2_ox_q} + $signed({2'b00, s2_ax_q});
  assign cy_d = {{2{s2_oy_q[15]}}, s2_oy_q} + $signed({2'b00, s2_ay_q});
  assign dx_d = {cx_d[17], cx_d, 2'b00} - {{3{s2_bw3_q[17]}}, s2_bw3_q};
  assign dy_d = {cy_d[17], cy_d, 2'b00} - {{3{s2_bh3_q[17]}}, s2_bh3_q};

  assign rxs  = $signed({1'b0, cfg_i.ratio_x});
  assign rys  = $signed({1'b0, cfg_i.ratio_y});
  assign px_d = s3_dx_q * rxs;
  assign py_d = s3_dy_q * rys;
  assign pw_d = s3_bw3_q * rxs;
  assign ph_d = s3_bh3_q * rys;

  // truncate toward zero: bias negatives before dropping the fraction
  assign px_b = s4_px_q + (s4_px_q[49] ? 50'sd4194303 : 50'sd0);
  assign py_b = s4_py_q + (s4_py_q[49] ? 50'sd4194303 : 50'sd0);
  assign pw_b = s4_pw_q + (s4_pw_q[46] ? 47'sd2097151 : 47'sd0);
  assign ph_b = s4_ph_q + (s4_ph_q[46] ? 47'sd2097151 : 47'sd0);

  assign side = (s5_w_q > s5_h_q) ? s5_w_q : s5_h_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_idx_q   <= in_data_i.det_index;
      s1_score_q <= in_data_i.score;
      s1_ox_q    <= in_data_i.off_x;
      s1_oy_q    <= in_data_i.off_y;
      s1_bw_q    <= in_data_i.box_w;
      s1_bh_q    <= in_data_i.box_h;
      s1_fx_q    <= fx_d;
      s1_fy_q    <= fy_d;
      s1_g16_q   <= g16_d;
    end
    if (adv[2]) begin
      s2_idx_q   <= s1_idx_q;
      s2_score_q <= s1_score_q;
      s2_ox_q    <= s1_ox_q;
      s2_oy_q    <= s1_oy_q;
      s2_ax_q    <= ax_d;
      s2_ay_q    <= ay_d;
      s2_bw3_q   <= (bw_e <<< 1) + bw_e;
      s2_bh3_q   <= (bh_e <<< 1) + bh_e;
    end
    if (adv[3]) begin
      s3_idx_q   <= s2_idx_q;
      s3_score_q <= s2_score_q;
      s3_cx_q    <= cx_d;
      s3_cy_q    <= cy_d;
      s3_dx_q    <= dx_d;
      s3_dy_q    <= dy_d;
      s3_bw3_q   <= s2_bw3_q;
      s3_bh3_q   <= s2_bh3_q;
    end
    if (adv[4]) begin
      s4_idx_q   <= s3_idx_q;
      s4_score_q <= s3_score_q;
      s4_cx_q    <= s3_cx_q;
      s4_cy_q    <= s3_cy_q;
      s4_px_q    <= px_d;
      s4_py_q    <= py_d;
      s4_pw_q    <= pw_d;
      s4_ph_q    <= ph_d;
    end
    if (adv[5]) begin
      s5_idx_q   <= s4_idx_q;
      s5_score_q <= s4_score_q;
      s5_cx_q    <= s4_cx_q;
      s5_cy_q    <= s4_cy_q;
      s5_left_q  <= px_b[49:22];
      s5_top_q   <= py_b[49:22];
      s5_w_q     <= pw_b[46:21];
      s5_h_q     <= ph_b[46:21];
    end
    if (adv[6]) begin
      s6_q.left      <= abd_pkg::sat16(s5_left_q);
      s6_q.top       <= abd_pkg::sat16(s5_top_q);
      s6_q.side_w    <= abd_pkg::sat16({{2{side[25]}}, side});
      s6_q.side_h    <= abd_pkg::sat16({{2{side[25]}}, side});
      s6_q.centre_x  <= abd_pkg::sat16({{10{s5_cx_q[17]}}, s5_cx_q});
      s6_q.centre_y  <= abd_pkg::sat16({{10{s5_cy_q[17]}}, s5_cy_q});
      s6_q.out_score <= s5_score_q;
      s6_q.out_index <= s5_idx_q;
    end
  end

  assign out_valid_o = v_q[6];
  assign out_data_o  = s6_q;

  `include "anchor_box_decoder_top_assert.svh"

  `ABD_ASSERT(a_low_score_dropped,
      in_acc && (in_data_i.score <= cfg_i.score_thr) |=> !v_q[1],
      "word at or below threshold entered pipeline")
  `ABD_ASSERT(a_square_sides, out_valid_o |-> out_data_o.side_w == out_data_o.side_h,
      "output box not square")
  `ABD_ASSERT(a_s1_held, v_q[1] && !adv[2] |=> v_q[1], "stalled stage 1 word lost")
  `ABD_ASSERT(a_no_accept_busy, cfg_busy_i |-> !in_acc, "word accepted during ratio update")

endmodule

[tb/tb_anchor_box_decoder_top.sv]
// Self-checking testbench for anchor_box_decoder_top: directed corners, then random
// register settings with random entry streams, checked against an in-bench box decoder.
// Depends on abd_pkg and the anchor_box_decoder_top RTL.
module tb_anchor_box_decoder_top;
  import abd_pkg::*;

  localparam int ClkHalf = 2;
  localparam int DrainTail = 12;
  localparam int TimeoutCycles = 400000;
  localparam int PhaseBoxes = 155;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  abd_in_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  abd_out_t out_word;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = CfgScoreThr;
  logic [15:0] cfg_data = '0;

  // register mirror, reset values
  logic [15:0] thr_q = ScoreThrRst;
  logic [9:0] ndet_q = NumDetRst;
  logic [11:0] imgw_q = ImgWRst;
  logic [11:0] imgh_q = ImgHRst;
  logic [10:0] mdlw_q = ModelWRst;
  logic [10:0] mdlh_q = ModelHRst;
  logic [10:0] ancw_q = AnchorWRst;
  logic [10:0] anch_q = AnchorHRst;

  abd_out_t pending_boxes[$];
  int n_sent = 0;
  int n_kept = 0;
  int n_checked = 0;
  int n_settings = 0;
  int err_count = 0;
  bit burst_mode = 1'b0;

  anchor_box_decoder_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #ClkHalf clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall <= !burst_mode && ($urandom_range(99) < 16);
  end

  function automatic logic signed [15:0] clip16(input longint v);
    logic signed [15:0] r;
    if (v > 32767) begin
      r = 16'sh7fff;
    end else if (v < -32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic bit decode_box(input abd_in_t e, output abd_out_t r);
    longint slot, gx, gy, ax, ay, cx, cy, rx, ry, bw, bh, lft, tp, w, h, dx, dy;
    r = '0;
    if (e.det_index >= ndet_q || e.det_index >= NumAnchors) return 1'b0;
    if (e.score <= thr_q) return 1'b0;
    if (e.det_index < Grid16Count) begin
      slot = longint'(e.det_index) / 2;
      gx = slot % 16;
      gy = slot / 16;
      ax = (longint'(ancw_q) * (2 * gx + 1)) / 2;
      ay = (longint'(anch_q) * (2 * gy + 1)) / 2;
    end else begin
      slot = (longint'(e.det_index) - Grid16Count) / 6;
      gx = slot % 8;
      gy = slot / 8;
      ax = longint'(ancw_q) * (2 * gx + 1);
      ay = longint'(anch_q) * (2 * gy + 1);
    end
    cx = longint'($signed(e.off_x)) + ax;
    cy = longint'($signed(e.off_y)) + ay;
    bw = longint'($signed(e.box_w));
    bh = longint'($signed(e.box_h));
    dx = (mdlw_q == 0) ? 1 : longint'(mdlw_q);
    dy = (mdlh_q == 0) ? 1 : longint'(mdlh_q);
    rx = (longint'(imgw_q) * 65536) / dx;
    ry = (longint'(imgh_q) * 65536) / dy;
    lft = ((4 * cx - 3 * bw) * rx) / 4194304;
    tp = ((4 * cy - 3 * bh) * ry) / 4194304;
    w = (3 * bw * rx) / 2097152;
    h = (3 * bh * ry) / 2097152;
    if (w > h) begin
      h = w;
    end else if (w < h) begin
      w = h;
    end
    r.left = clip16(lft);
    r.top = clip16(tp);
    r.side_w = clip16(w);
    r.side_h = clip16(h);
    r.centre_x = clip16(cx);
    r.centre_y = clip16(cy);
    r.out_score = e.score;
    r.out_index = e.det_index;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    abd_out_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_boxes.size() == 0) begin
        $error("output word with no expected box (index %0d)", out_word.out_index);
        err_count++;
      end else begin
        e = pending_boxes.pop_front();
        n_checked++;
        check_field("left", int'($signed(e.left)), int'($signed(out_word.left)));
        check_field("top", int'($signed(e.top)), int'($signed(out_word.top)));
        check_field("side_w", int'($signed(e.side_w)), int'($signed(out_word.side_w)));
        check_field("side_h", int'($signed(e.side_h)), int'($signed(out_word.side_h)));
        check_field("centre_x", int'($signed(e.centre_x)), int'($signed(out_word.centre_x)));
        check_field("centre_y", int'($signed(e.centre_y)), int'($signed(out_word.centre_y)));
        check_field("out_score", int'(e.out_score), int'(out_word.out_score));
        check_field("out_index", int'(e.out_index), int'(out_word.out_index));
      end
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_entry(input abd_in_t e);
    abd_out_t r;
    while (!burst_mode && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= e;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    n_sent++;
    if (decode_box(e, r)) begin
      pending_boxes.insert(pending_boxes.size(), r);
      n_kept++;
    end
    @(negedge clk_i);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(val);
    case (idx)
      CfgScoreThr: thr_q = 16'(val);
      CfgNumDet: ndet_q = 10'(val);
      CfgImgW: imgw_q = 12'(val);
      CfgImgH: imgh_q = 12'(val);
      CfgModelW: mdlw_q = 11'(val);
      CfgModelH: mdlh_q = 11'(val);
      CfgAnchorW: ancw_q = 11'(val);
      default: anch_q = 11'(val);
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input int thr, input int nd, input int iw, input int ih,
                            input int mw, input int mh, input int aw, input int ah);
    wait_results();
    repeat (DrainTail) @(negedge clk_i);
    write_reg(CfgScoreThr, thr);
    write_reg(CfgNumDet, nd);
    write_reg(CfgImgW, iw);
    write_reg(CfgImgH, ih);
    write_reg(CfgModelW, mw);
    write_reg(CfgModelH, mh);
    write_reg(CfgAnchorW, aw);
    write_reg(CfgAnchorH, ah);
    n_settings++;
  endtask

  function automatic abd_in_t mk(input int idx, input int sc, input int ox, input int oy,
                                 input int bw, input int bh);
    abd_in_t e;
    e.det_index = 10'(idx);
    e.score = 16'(sc);
    e.off_x = 16'(ox);
    e.off_y = 16'(oy);
    e.box_w = 16'(bw);
    e.box_h = 16'(bh);
    return e;
  endfunction

  function automatic logic [15:0] rand_q114();
    logic [15:0] v;
    case ($urandom_range(9))
      0: v = 16'h7fff;
      1: v = 16'h8000;
      2, 3, 4, 5: v = 16'($urandom);
      default: v = 16'($urandom_range(4095) - 2048);
    endcase
    return v;
  endfunction

  function automatic abd_in_t random_word();
    abd_in_t e;
    int lim;
    int mode;
    lim = (ndet_q < NumAnchors) ? int'(ndet_q) : NumAnchors;
    mode = $urandom_range(99);
    if (mode < 80 && lim > 0 && thr_q != 16'hffff) begin
      e.det_index = 10'($urandom_range(lim - 1));
      e.score = 16'($urandom_range(65535, int'(thr_q) + 1));
    end else if (mode < 88) begin
      e.det_index = 10'($urandom);
      e.score = 16'($urandom);
    end else if (mode < 94) begin
      e.det_index = 10'(lim);
      e.score = 16'($urandom);
    end else begin
      e.det_index = 10'($urandom_range(1023));
      e.score = thr_q;
    end
    e.off_x = rand_q114();
    e.off_y = rand_q114();
    e.box_w = rand_q114();
    e.box_h = rand_q114();
    return e;
  endfunction

  task automatic run_random(input int target);
    int k0;
    int s0;
    k0 = n_kept;
    s0 = n_sent;
    while (n_kept - k0 < target && n_sent - s0 < 4 * target) send_entry(random_word());
  endtask

  task automatic test_reset_defaults();
    send_entry(mk(0, 65535, 0, 0, 0, 0));
    send_entry(mk(1, 55707, 16, 16, 160, 160));
    send_entry(mk(2, 55706, 16, 16, 160, 160));
    send_entry(mk(3, 0, 0, 0, 0, 0));
    send_entry(mk(511, 60000, 32767, -32768, 100, 50));
    send_entry(mk(512, 60000, -32768, 32767, 50, 100));
    send_entry(mk(895, 60000, -32, 48, -200, -120));
    send_entry(mk(896, 65535, 0, 0, 10, 10));
    send_entry(mk(1023, 65535, 0, 0, 10, 10));
    send_entry(mk(100, 65535, 0, 0, 32767, 32767));
    send_entry(mk(101, 65535, 0, 0, -32768, -32768));
    send_entry(mk(517, 65535, 3, -3, 32767, -32768));
    send_entry(mk(518, 65535, -5, 5, -32768, 32767));
    send_entry(mk(31, 65535, 32767, 32767, 0, 0));
    send_entry(mk(767, 65535, -32768, -32768, 1, -1));
    send_entry(mk(255, 58000, 12, -12, 33, 33));
  endtask

  task automatic test_degenerate_sizes();
    // zero model size divides by one, zero anchor span puts every anchor at zero
    set_config(0, 1023, 640, 480, 0, 0, 0, 0);
    send_entry(mk(0, 1, 0, 0, 0, 0));
    send_entry(mk(10, 0, 5, 5, 5, 5));
    send_entry(mk(600, 100, 50, -50, 300, 200));
    send_entry(mk(895, 65535, -32768, 32767, 32767, -32768));
    send_entry(mk(900, 65535, 1, 1, 1, 1));
  endtask

  task automatic test_random_configs();
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(ScoreThrRst, NumDetRst, ImgWRst, ImgHRst,
                      ModelWRst, ModelHRst, AnchorWRst, AnchorHRst);
        1: set_config(0, 1, 1, 1, 1024, 1024, 1, 1);
        2: set_config(65534, 1023, 4095, 4095, 1, 1, 1024, 1024);
        3: set_config(0, 896, 4095, 1, 1024, 1, 1024, 1);
        default: set_config($urandom_range(65535), $urandom_range(1023, 1),
                            $urandom_range(4095, 1), $urandom_range(4095, 1),
                            $urandom_range(1024, 1), $urandom_range(1024, 1),
                            $urandom_range(1024, 1), $urandom_range(1024, 1));
      endcase
      run_random(PhaseBoxes);
    end
  endtask

  task automatic test_nothing_passes();
    set_config(65535, 0, 320, 240, 128, 128, 128, 128);
    repeat (40) send_entry(random_word());
  endtask

  task automatic test_full_rate();
    set_config($urandom_range(40000), 896, 1280, 720, 256, 256, 256, 256);
    burst_mode = 1'b1;
    run_random(PhaseBoxes);
    wait_results();
    burst_mode = 1'b0;
  endtask

  task automatic test_pause_midstream();
    set_config($urandom_range(50000), $urandom_range(896, 600), $urandom_range(4095, 1),
               $urandom_range(4095, 1), $urandom_range(1024, 1), $urandom_range(1024, 1),
               $urandom_range(1024, 1), $urandom_range(1024, 1));
    run_random(PhaseBoxes / 2);
    wait_results();
    run_random(PhaseBoxes / 2);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_degenerate_sizes();
    test_random_configs();
    test_nothing_passes();
    test_full_rate();
    test_pause_midstream();
    in_valid <= 1'b0;
    for (int i = 0; i < 20000 && pending_boxes.size() != 0; i++) @(negedge clk_i);
    repeat (DrainTail) @(negedge clk_i);
    if (pending_boxes.size() != 0) begin
      $error("%0d expected boxes never arrived", pending_boxes.size());
      err_count++;
    end
    $display("sent %0d entries over %0d register settings, %0d decoded boxes checked",
             n_sent, n_settings + 1, n_checked);
    $display("%0d entries dropped by index or score, %0d errors", n_sent - n_kept, err_count);
    if (err_count == 0) begin
      $display("anchor_box_decoder_top regression: pass");
    end else begin
      $display("anchor_box_decoder_top regression: fail");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * 2 * ClkHalf);
    $display("timeout with %0d boxes outstanding", pending_boxes.size());
    $display("anchor_box_decoder_top regression: fail");
    $finish;
  end

endmodule
